// File: rtl/pigr_pkg.sv
// Package for the pose innovation gate with relock.
// Holds the configuration record, the controller command and status records
// and the register index codes. It depends on nothing else.
package pigr_pkg;

    localparam int POS_W   = 24;
    localparam int ANG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int GATE_W  = 16;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GATE_ENABLE   = 3'd0,
        REG_XY_GATE_BASE  = 3'd1,
        REG_YAW_GATE_BASE = 3'd2,
        REG_XY_GROWTH     = 3'd3,
        REG_YAW_GROWTH    = 3'd4,
        REG_XY_GATE_MAX   = 3'd5,
        REG_YAW_GATE_MAX  = 3'd6,
        REG_RELOCK_TIME   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        gate_enable;
        logic [15:0] xy_gate_base;
        logic [14:0] yaw_gate_base;
        logic [15:0] xy_growth;
        logic [14:0] yaw_growth;
        logic [15:0] xy_gate_max;
        logic [14:0] yaw_gate_max;
        logic [23:0] relock_time;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic mult;
        logic gate;
        logic square;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/pigr_ctrl.sv
// Controller state machine of the pose innovation gate.
// Steps the datapath through its stages one request at a time.
// Depends on pigr_pkg.
module pigr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pigr_pkg::sts_t sts,
    output pigr_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIFF   = 6'b000010,
        ST_MULT   = 6'b000100,
        ST_GATE   = 6'b001000,
        ST_SQUARE = 6'b010000,
        ST_DECIDE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_GATE;
            end
            ST_GATE: begin
                cmd.gate   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!sts.out_busy) begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/pigr_datapath.sv
// Datapath of the pose innovation gate: error terms, time-grown gates,
// squared distance test, relock tracking and the result register.
// Depends on pigr_pkg.
module pigr_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pigr_pkg::cfg_t                     cfg,
    input  pigr_pkg::cmd_t                     cmd,
    output pigr_pkg::sts_t                     sts,
    input  logic [pigr_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pigr_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    function automatic logic [15:0] gate_clip(input logic [15:0] base,
                                              input logic [37:0] term,
                                              input logic [15:0] cap);
        logic [38:0] sum;
        sum = {23'd0, base} + {1'b0, term};
        if (sum < {23'd0, cap}) begin
            return sum[15:0];
        end
        return cap;
    endfunction

    logic [23:0] meas_x_reg, meas_y_reg, est_x_reg, est_y_reg;
    logic [15:0] meas_heading_reg, est_heading_reg;
    logic        est_valid_reg;
    logic [31:0] now_reg;

    logic [31:0] age_reg;
    logic [24:0] ax_reg, ay_reg;
    logic [15:0] ayaw_reg;
    logic [47:0] prod_xy_reg;
    logic [46:0] prod_yaw_reg;
    logic [49:0] sqx_reg, sqy_reg;
    logic [15:0] gxy_reg, gyaw_reg;
    logic [50:0] d2_reg;
    logic [31:0] gxy2_reg;
    logic        yaw_ok_reg;

    logic        have_accept_reg, have_accept_next;
    logic [31:0] accept_time_reg, accept_time_next;
    logic        rejecting_reg, rejecting_next;
    logic [31:0] reject_start_reg, reject_start_next;
    logic        m_tvalid_reg;
    logic        accept_reg, relocked_reg;
    logic        acc_next, relock_next;

    logic signed [24:0] dx, dy;
    logic [15:0] dh;
    logic [31:0] run_start;
    logic [31:0] elapsed;
    logic        bypass;
    logic        pass;

    assign dx = {meas_x_reg[23], meas_x_reg} - {est_x_reg[23], est_x_reg};
    assign dy = {meas_y_reg[23], meas_y_reg} - {est_y_reg[23], est_y_reg};
    assign dh = meas_heading_reg - est_heading_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            meas_x_reg       <= s_tdata[23:0];
            meas_y_reg       <= s_tdata[47:24];
            meas_heading_reg <= s_tdata[63:48];
            est_x_reg        <= s_tdata[87:64];
            est_y_reg        <= s_tdata[111:88];
            est_heading_reg  <= s_tdata[127:112];
            now_reg          <= s_tdata[159:128];
            est_valid_reg    <= s_tuser;
        end
        if (cmd.diff) begin
            age_reg  <= now_reg - accept_time_reg;
            ax_reg   <= dx[24] ? 25'(-dx) : 25'(dx);
            ay_reg   <= dy[24] ? 25'(-dy) : 25'(dy);
            ayaw_reg <= dh[15] ? 16'(~dh + 16'd1) : dh;
        end
        if (cmd.mult) begin
            prod_xy_reg  <= {32'd0, cfg.xy_growth} * {16'd0, age_reg};
            prod_yaw_reg <= {32'd0, cfg.yaw_growth} * {15'd0, age_reg};
            sqx_reg      <= {25'd0, ax_reg} * {25'd0, ax_reg};
            sqy_reg      <= {25'd0, ay_reg} * {25'd0, ay_reg};
        end
        if (cmd.gate) begin
            gxy_reg  <= gate_clip(cfg.xy_gate_base, prod_xy_reg[47:10], cfg.xy_gate_max);
            gyaw_reg <= gate_clip({1'b0, cfg.yaw_gate_base}, {1'b0, prod_yaw_reg[46:10]},
                                  {1'b0, cfg.yaw_gate_max});
            d2_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
        if (cmd.square) begin
            gxy2_reg   <= {16'd0, gxy_reg} * {16'd0, gxy_reg};
            yaw_ok_reg <= (ayaw_reg <= gyaw_reg);
        end
        if (cmd.decide) begin
            accept_reg   <= acc_next;
            relocked_reg <= relock_next;
        end
    end

    assign bypass    = !cfg.gate_enable || !have_accept_reg || !est_valid_reg;
    assign pass      = (d2_reg <= {19'd0, gxy2_reg}) && yaw_ok_reg;
    assign run_start = rejecting_reg ? reject_start_reg : now_reg;
    assign elapsed   = now_reg - run_start;

    always_comb begin
        rejecting_next    = rejecting_reg;
        reject_start_next = reject_start_reg;
        acc_next          = 1'b0;
        relock_next       = 1'b0;
        if (bypass) begin
            acc_next = 1'b1;
        end else if (pass) begin
            rejecting_next = 1'b0;
            acc_next       = 1'b1;
        end else begin
            rejecting_next    = 1'b1;
            reject_start_next = run_start;
            if (elapsed > {8'd0, cfg.relock_time}) begin
                rejecting_next = 1'b0;
                acc_next       = 1'b1;
                relock_next    = 1'b1;
            end
        end
        have_accept_next = have_accept_reg | acc_next;
        accept_time_next = acc_next ? now_reg : accept_time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_accept_reg  <= 1'b0;
            accept_time_reg  <= '0;
            rejecting_reg    <= 1'b0;
            reject_start_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cmd.decide) begin
                have_accept_reg  <= have_accept_next;
                accept_time_reg  <= accept_time_next;
                rejecting_reg    <= rejecting_next;
                reject_start_reg <= reject_start_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_busy = m_tvalid_reg & ~m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {7'd0, accept_reg};
    assign m_tuser      = relocked_reg;

endmodule

// File: rtl/pose_innovation_gate_with_relock.sv
// Pose innovation gate with relock: configuration registers and top level.
// Each request is accepted in the idle state and passes the diff, mult, gate,
// square and decide states of the controller before its result is valid; a new
// request is taken only once the last has left decide, which waits while a result stalls.
// Reset is synchronous and active low; it restores register defaults and
// clears the accept history and the rejection run. Depends on pigr_pkg.
module pose_innovation_gate_with_relock (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pigr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pigr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pigr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // meas_x, meas_y, meas_heading, est_x, est_y, est_heading, now_ms
    input  logic [pigr_pkg::IN_DATA_W-1:0]     s_tdata,
    // est_valid
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // accept, then zero padding
    output logic [pigr_pkg::OUT_DATA_W-1:0]    m_tdata,
    // relocked
    output logic                               m_tuser
);

    pigr_pkg::cfg_t     cfg_reg;
    pigr_pkg::cmd_t     cmd;
    pigr_pkg::sts_t     sts;
    pigr_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign reg_idx = pigr_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_enable   <= 1'b1;
            cfg_reg.xy_gate_base  <= 16'd500;
            cfg_reg.yaw_gate_base <= 15'd3651;
            cfg_reg.xy_growth     <= 16'd205;
            cfg_reg.yaw_growth    <= 15'd2136;
            cfg_reg.xy_gate_max   <= 16'd1500;
            cfg_reg.yaw_gate_max  <= 15'd15646;
            cfg_reg.relock_time   <= 24'd10000;
        end else if (wr_en) begin
            case (reg_idx)
                pigr_pkg::REG_GATE_ENABLE:   cfg_reg.gate_enable   <= pwdata[0];
                pigr_pkg::REG_XY_GATE_BASE:  cfg_reg.xy_gate_base  <= pwdata[15:0];
                pigr_pkg::REG_YAW_GATE_BASE: cfg_reg.yaw_gate_base <= pwdata[14:0];
                pigr_pkg::REG_XY_GROWTH:     cfg_reg.xy_growth     <= pwdata[15:0];
                pigr_pkg::REG_YAW_GROWTH:    cfg_reg.yaw_growth    <= pwdata[14:0];
                pigr_pkg::REG_XY_GATE_MAX:   cfg_reg.xy_gate_max   <= pwdata[15:0];
                pigr_pkg::REG_YAW_GATE_MAX:  cfg_reg.yaw_gate_max  <= pwdata[14:0];
                pigr_pkg::REG_RELOCK_TIME:   cfg_reg.relock_time   <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pigr_pkg::REG_GATE_ENABLE:   prdata = {31'd0, cfg_reg.gate_enable};
            pigr_pkg::REG_XY_GATE_BASE:  prdata = {16'd0, cfg_reg.xy_gate_base};
            pigr_pkg::REG_YAW_GATE_BASE: prdata = {17'd0, cfg_reg.yaw_gate_base};
            pigr_pkg::REG_XY_GROWTH:     prdata = {16'd0, cfg_reg.xy_growth};
            pigr_pkg::REG_YAW_GROWTH:    prdata = {17'd0, cfg_reg.yaw_growth};
            pigr_pkg::REG_XY_GATE_MAX:   prdata = {16'd0, cfg_reg.xy_gate_max};
            pigr_pkg::REG_YAW_GATE_MAX:  prdata = {17'd0, cfg_reg.yaw_gate_max};
            pigr_pkg::REG_RELOCK_TIME:   prdata = {8'd0, cfg_reg.relock_time};
            default:                     prdata = '0;
        endcase
    end

    pigr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pigr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
